FILE: hdl/lse_pkg.sv
// lse_pkg: shared types and constants of the log-sum-exp reduction block
// no dependencies

package lse_pkg;

    localparam int VAL_W = 24;
    localparam int EXP_STEPS = 24;
    localparam int LOG_STEPS = 24;
    localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // item handed from the front part to the back part
    typedef struct packed {
        logic [12:0] count;
        logic [11:0] max_pos;
        logic signed [VAL_W-1:0] max_val;
        logic dropped;
    } lse_job_t;

    // floor integer square root, used only to build the factor table
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    typedef logic [EXP_STEPS:0][32:0] pow_tab_t;

    // 2^(-2^-i) in Q.32, built by repeated floor square roots
    function automatic pow_tab_t build_pow_tab();
        pow_tab_t t;
        logic [63:0] prev;
        t = '0;
        prev = isqrt64(64'd1 << 63);
        t[1] = prev[32:0];
        for (int i = 2; i <= EXP_STEPS; i++)
        begin
            prev = isqrt64(prev << 32);
            t[i] = prev[32:0];
        end
        return t;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow_tab();

    function automatic logic [32:0] pow_factor(input logic [4:0] idx);
        logic [32:0] t;
        t = 33'd0;
        if (idx <= 5'(EXP_STEPS))
            t = POW_TAB[idx];
        return t;
    endfunction

endpackage

FILE: hdl/log_sum_exp_reduce.sv
// log_sum_exp_reduce: top level of the log-sum-exp reduction block
// depends on lse_pkg, lse_front, lse_back
//
// Usage: summands (signed Q8.16) are pushed as items with push/full; the
// item with last set closes the run. One result item (result, count,
// overflow) then appears on the result side; empty low shows it, pop takes
// it. Summands past MAX_TERMS are dropped and flag overflow.
// The front part stores each summand as it is accepted. On last, the back
// part walks the stored run: memory read, exponent multiply, 24 one-bit
// exponent steps and accumulate per summand, skipping the maximum's slot;
// then an end check and a setup step; for two or more summands, k normalize
// shifts (k at most 8 for 256 summands), 24 log squaring steps, final steps.
// From the last item until the back part has read the whole run, full stays
// high; after that the next run can be stored while the sum is finished.
// Reset clears all run state; the summand memory is not cleared.
// A stalled result (pop low) holds the back part; the front part may still
// take one complete further run meanwhile.

module log_sum_exp_reduce
    import lse_pkg::*;
#(
    parameter int MAX_TERMS = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  logic signed [23:0] value,
    input  logic last,
    output logic empty,
    input  logic pop,
    output logic signed [23:0] result,
    output logic [8:0] count,
    output logic overflow
);

    localparam int AW = $clog2(MAX_TERMS);
    localparam int CW = $clog2(MAX_TERMS + 1);

    logic job_valid, job_ready, res_valid;
    lse_job_t job;
    logic [AW-1:0] rd_addr;
    logic signed [VAL_W-1:0] rd_data;

    lse_front #(.MAX_TERMS(MAX_TERMS), .AW(AW)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .value(value),
        .last(last), .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    lse_back #(.AW(AW), .CW(CW)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
        .job(job), .rd_addr(rd_addr), .rd_data(rd_data), .res_valid(res_valid),
        .res_take(pop), .res_val(result), .res_cnt(count), .res_ovf(overflow)
    );

    assign empty = !res_valid;

endmodule

FILE: hdl/lse_front.sv
// lse_front: accepts summands, stores them, tracks the first strict maximum
// depends on lse_pkg; owns the summand memory, read by the back part

module lse_front
    import lse_pkg::*;
#(
    parameter int MAX_TERMS = 256,
    parameter int AW = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  logic signed [VAL_W-1:0] value,
    input  logic last,
    output logic job_valid,
    input  logic job_ready,
    output lse_job_t job,
    input  logic [AW-1:0] rd_addr,
    output logic signed [VAL_W-1:0] rd_data
);

    logic signed [VAL_W-1:0] mem [MAX_TERMS];
    logic [AW:0] cnt_reg, cnt_next;
    logic signed [VAL_W-1:0] max_reg, max_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic drop_reg, drop_next;
    logic job_valid_reg;
    lse_job_t job_reg;
    logic room, acc;

    // the memory belongs to the waiting job until the back part releases it
    assign full = job_valid_reg;
    assign acc = push && !full;
    assign room = (cnt_reg < (AW+1)'(MAX_TERMS));
    assign job_valid = job_valid_reg;
    assign job = job_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (acc && room)
            mem[cnt_reg[AW-1:0]] <= value;
        rd_data <= mem[rd_addr];
    end

    // run state update
    always_comb
    begin
        cnt_next = cnt_reg;
        max_next = max_reg;
        pos_next = pos_reg;
        drop_next = drop_reg;
        if (acc)
        begin
            if (room)
            begin
                if (cnt_reg == '0 || value > max_reg)
                begin
                    max_next = value;
                    pos_next = cnt_reg[AW-1:0];
                end
                cnt_next = cnt_reg + 1'b1;
            end
            else
                drop_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            max_reg <= '0;
            pos_reg <= '0;
            drop_reg <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid_reg && job_ready)
                job_valid_reg <= 1'b0;
            if (acc && last)
            begin
                job_valid_reg <= 1'b1;
                cnt_reg <= '0;
                max_reg <= '0;
                pos_reg <= '0;
                drop_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                max_reg <= max_next;
                pos_reg <= pos_next;
                drop_reg <= drop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && last)
        begin
            job_reg.count <= 13'(cnt_next);
            job_reg.max_pos <= 12'(pos_next);
            job_reg.max_val <= max_next;
            job_reg.dropped <= drop_next;
        end
    end

    // one job only while the back part owns the memory
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !job_ready |=> job_valid_reg)
        else $error("job dropped");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(MAX_TERMS))
        else $error("count beyond depth");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        acc && last |=> cnt_reg == '0)
        else $error("run not cleared");

endmodule

FILE: hdl/lse_back.sv
// lse_back: gives max + ln(1 + sum of exp(v - max)), skipping max's slot
// depends on lse_pkg; reads the front part's memory one entry at a time

module lse_back
    import lse_pkg::*;
#(
    parameter int AW = 8,
    parameter int CW = 9
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_ready,
    input  lse_job_t job,
    output logic [AW-1:0] rd_addr,
    input  logic signed [VAL_W-1:0] rd_data,
    output logic res_valid,
    input  logic res_take,
    output logic signed [VAL_W-1:0] res_val,
    output logic [8:0] res_cnt,
    output logic res_ovf
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD = 4'd1;
    localparam logic [3:0] S_MUL = 4'd2;
    localparam logic [3:0] S_EXP = 4'd3;
    localparam logic [3:0] S_ACC = 4'd4;
    localparam logic [3:0] S_NORM = 4'd5;
    localparam logic [3:0] S_SQ = 4'd6;
    localparam logic [3:0] S_LN = 4'd7;
    localparam logic [3:0] S_FIN = 4'd8;
    localparam logic [3:0] S_OUT = 4'd9;

    logic [3:0] st_reg;
    logic [CW:0] idx_reg;
    logic [CW:0] cnt_reg;
    logic [11:0] pos_reg;
    logic signed [VAL_W-1:0] max_reg;
    logic drop_reg;
    logic [63:0] sum_reg;
    logic [57:0] y_reg;
    logic [32:0] e_reg;
    logic [4:0] step_reg;
    logic [63:0] m_reg;
    logic [5:0] k_reg;
    logic [29:0] lg_reg;
    logic [61:0] p_reg;
    logic signed [VAL_W-1:0] out_val_reg;
    logic [8:0] out_cnt_reg;
    logic out_ovf_reg;
    logic [24:0] d;
    logic [65:0] prod;
    logic [64:0] L;
    logic [63:0] sqp;
    logic [64:0] sq;
    logic [33:0] m2;
    logic signed [26:0] r;

    // the job and its memory are released once the read pass is done
    assign job_ready = (st_reg == S_NORM);
    assign res_valid = (st_reg == S_OUT);
    assign res_val = out_val_reg;
    assign res_cnt = out_cnt_reg;
    assign res_ovf = out_ovf_reg;
    assign rd_addr = idx_reg[AW-1:0];

    // datapath helpers
    assign d = 25'(max_reg) - 25'(rd_data);
    assign prod = e_reg * pow_factor(step_reg) + 66'h80000000;
    assign L = {1'b0, sum_reg} + 65'h100000000;
    assign sqp = m_reg[31:0] * m_reg[31:0];
    assign sq = {1'b0, sqp} + 65'h40000000;
    assign m2 = sq[64:31];
    assign r = 27'(max_reg) + 27'(signed'({1'b0, p_reg[61:40]} + 23'(p_reg[39])));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= S_IDLE;
        else
        begin
            case (st_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        cnt_reg <= (CW+1)'(job.count);
                        pos_reg <= job.max_pos;
                        max_reg <= job.max_val;
                        drop_reg <= job.dropped;
                        idx_reg <= '0;
                        sum_reg <= '0;
                        st_reg <= S_RD;
                    end
                // address presented, data comes next cycle
                S_RD:
                    if (idx_reg >= cnt_reg)
                        st_reg <= S_NORM;
                    else if (12'(idx_reg) == pos_reg)
                        idx_reg <= idx_reg + 1'b1;
                    else
                        st_reg <= S_MUL;
                S_MUL:
                begin
                    y_reg <= 58'(d) * 58'(LOG2E_Q32);
                    e_reg <= 33'h100000000;
                    step_reg <= 5'd1;
                    st_reg <= S_EXP;
                end
                // one fraction bit of the exponent per cycle
                S_EXP:
                begin
                    if (y_reg[6'd48 - 6'(step_reg)])
                        e_reg <= prod[64:32];
                    if (step_reg == 5'(EXP_STEPS))
                        st_reg <= S_ACC;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_ACC:
                begin
                    if (y_reg[57:53] == '0)
                        sum_reg <= sum_reg + 64'(e_reg >> y_reg[52:48]);
                    idx_reg <= idx_reg + 1'b1;
                    st_reg <= S_RD;
                end
                // setup; S_SQ normalizes leading one, one bit per cycle
                S_NORM:
                begin
                    if (cnt_reg <= 1)
                    begin
                        out_val_reg <= max_reg;
                        st_reg <= S_FIN;
                    end
                    else
                    begin
                        k_reg <= '0;
                        m_reg <= 64'(L >> 1);
                        lg_reg <= '0;
                        step_reg <= 5'd1;
                        st_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (m_reg[63:32] != '0)
                    begin
                        k_reg <= k_reg + 1'b1;
                        m_reg <= m_reg >> 1;
                    end
                    else
                    begin
                        lg_reg <= {k_reg, 24'd0};
                        st_reg <= S_LN;
                    end
                end
                S_LN:
                begin
                    if (m2[32])
                    begin
                        lg_reg[5'(LOG_STEPS) - step_reg] <= 1'b1;
                        m_reg <= 64'(m2 >> 1);
                    end
                    else
                        m_reg <= 64'(m2);
                    if (step_reg == 5'(LOG_STEPS))
                    begin
                        step_reg <= 5'd0;
                        st_reg <= S_FIN;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_FIN:
                begin
                    if (cnt_reg > 1)
                    begin
                        if (step_reg == 5'd0)
                        begin
                            p_reg <= 62'(lg_reg) * 62'(LN2_Q32);
                            step_reg <= 5'd1;
                        end
                        else
                        begin
                            if (r > 27'sd8388607)
                                out_val_reg <= 24'sd8388607;
                            else if (r < -27'sd8388608)
                                out_val_reg <= -24'sd8388608;
                            else
                                out_val_reg <= r[23:0];
                            out_cnt_reg <= 9'(cnt_reg);
                            out_ovf_reg <= drop_reg;
                            st_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        out_cnt_reg <= 9'(cnt_reg);
                        out_ovf_reg <= drop_reg;
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                    if (res_take)
                        st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_take |=> res_valid && $stable(out_val_reg))
        else $error("result changed while waiting");
    a_take_once: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_take |=> !res_valid)
        else $error("result repeated");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_ACC |-> idx_reg < cnt_reg)
        else $error("read beyond run");

endmodule
